// File: rtl/rtt_pkg.sv
package rtt_pkg;

   // Item kinds carried in req_tuser. Codes five to seven mean nothing.
   typedef enum logic [2:0] {
      FUNC_WRITE        = 3'd0,
      FUNC_V2P          = 3'd1,
      FUNC_P2V_CACHED   = 3'd2,
      FUNC_P2V_UNCACHED = 3'd3,
      FUNC_RANGE_CHECK  = 3'd4
   } func_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_ENTRY_COUNT = 2'd0,
      REG_VIEW_MASK   = 2'd1
   } csr_reg_type;

   localparam int ADDR_W      = 32;
   localparam int IDX_W       = 6;
   localparam int COUNT_W     = 7;
   localparam int VIEW_W      = 16;
   localparam int VIEW_LSB    = 16;
   localparam int UNCACHED_B  = 30;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int FUNC_W      = 3;
   localparam int REQ_DATA_W  = 200;
   // Wide enough to compare a slot number (up to 256) with the entry count.
   localparam int SLOT_CMP_W  = 9;

   // Entry write, broadcast to every cell at the accepting edge.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] vbase;
      logic [ADDR_W-1:0] pbase;
      logic [ADDR_W-1:0] len;
      logic [ADDR_W-1:0] attr;
   } wr_type;

   // Token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic              valid;
      func_type          func;
      logic [ADDR_W-1:0] qa;
      logic [ADDR_W:0]   qend;
      logic              found;
      logic [ADDR_W-1:0] addr;
   } tok_type;

endpackage

// File: rtl/range_translation_table.sv
// Range translation table. The block holds ENTRIES range mappings, one in
// each cell of a row, and answers one request per transfer on the req_
// channel with one response transfer on the rsp_ channel. A write request
// loads its slot at the very edge of the transfer; every other request
// becomes a token that walks the cell row, one cell per clock, and picks up
// the first active entry that matches, lowest index first. Every request,
// writes included, therefore passes the whole cell row, and the block works
// on one request at a time. A finished response waits in the output register
// while the next request is already taken; a second result slot keeps the
// row free of back pressure. Configuration (entry count and view mask) is
// written on the csr_ channel, which is always ready. Table slots must be
// read only after they have been written; the user must ensure this, as the
// block does not enforce it. They carry no reset.
module range_translation_table
   import rtt_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // From bit 0 up: entry_index[6], entry_virt_base[32], entry_phys_base[32],
   // entry_length[32], entry_attr[32], query_addr[32], query_length[32],
   // two zero bits.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // From bit 0 up: func[3].
   input  logic [FUNC_W-1:0]     req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0 up: out_addr[32].
   output logic [ADDR_W-1:0]     rsp_tdata,
   // From bit 0 up: found[1].
   output logic                  rsp_tuser,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Request fields.
   logic [IDX_W-1:0]  f_idx;
   logic [ADDR_W-1:0] f_vbase;
   logic [ADDR_W-1:0] f_pbase;
   logic [ADDR_W-1:0] f_len;
   logic [ADDR_W-1:0] f_attr;
   logic [ADDR_W-1:0] f_qa;
   logic [ADDR_W-1:0] f_ql;
   func_type          f_func;

   assign f_idx   = req_tdata[5:0];
   assign f_vbase = req_tdata[37:6];
   assign f_pbase = req_tdata[69:38];
   assign f_len   = req_tdata[101:70];
   assign f_attr  = req_tdata[133:102];
   assign f_qa    = req_tdata[165:134];
   assign f_ql    = req_tdata[197:166];
   assign f_func  = func_type'(req_tuser);

   // Configuration registers.
   logic [COUNT_W-1:0] entry_count_ff;
   logic [VIEW_W-1:0]  view_mask_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         view_mask_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_ENTRY_COUNT: entry_count_ff <= csr_data[COUNT_W-1:0];
            REG_VIEW_MASK:   view_mask_ff   <= csr_data[VIEW_W-1:0];
            default:         ;
         endcase
      end
   end

   // Control: one request in the row at a time, and no new request while
   // the spare result slot is occupied.
   logic run_ff;
   logic run_in;
   logic req_fire;
   logic rsp_fire;

   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              hold_valid_ff;
   logic              hold_found_ff;
   logic [ADDR_W-1:0] hold_addr_ff;

   assign req_tready = !run_ff && !hold_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   // The write goes to every cell at once; the matching slot loads it.
   wr_type wr;

   always_comb begin
      wr.en    = req_fire && (f_func == FUNC_WRITE);
      wr.idx   = f_idx;
      wr.vbase = f_vbase;
      wr.pbase = f_pbase;
      wr.len   = f_len;
      wr.attr  = f_attr;
   end

   // Token chain: entry 0 is the token formed from the request, entry i + 1
   // leaves cell i.
   tok_type head;
   tok_type chain [0:ENTRIES];

   always_comb begin
      head.valid = req_fire;
      head.func  = f_func;
      head.qa    = f_qa;
      head.qend  = {1'b0, f_qa} + {1'b0, f_ql};
      // A write into an existing slot reports found; the cells never match
      // a write, so this passes the row unchanged.
      head.found = (f_func == FUNC_WRITE) &&
                   (SLOT_CMP_W'(f_idx) < SLOT_CMP_W'(ENTRIES));
      head.addr  = '0;
   end

   assign chain[0] = head;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      rtt_cell #(
         .INDEX(g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr          (wr),
         .entry_count (entry_count_ff),
         .view_mask   (view_mask_ff),
         .up_tok      (chain[g]),
         .dn_tok      (chain[g+1])
      );
   end

   tok_type tail;
   assign tail = chain[ENTRIES];

   always_comb begin
      run_in = run_ff;
      if (req_fire) begin
         run_in = 1'b1;
      end else if (tail.valid) begin
         run_in = 1'b0;
      end
   end

   // Output register and spare slot. The spare slot only fills when a
   // result leaves the row while the previous one is still waiting.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         if (hold_valid_ff) begin
            if (rsp_fire) begin
               rsp_found_ff  <= hold_found_ff;
               rsp_addr_ff   <= hold_addr_ff;
               hold_valid_ff <= 1'b0;
            end
         end else if (tail.valid) begin
            if (!rsp_valid_ff || rsp_fire) begin
               rsp_valid_ff <= 1'b1;
               rsp_found_ff <= tail.found;
               rsp_addr_ff  <= tail.addr;
            end else begin
               hold_valid_ff <= 1'b1;
               hold_found_ff <= tail.found;
               hold_addr_ff  <= tail.addr;
            end
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_found_ff;

   logic [ENTRIES-1:0] tok_valid_vec;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_vld
      assign tok_valid_vec[g] = chain[g+1].valid;
   end

   // At most one token is ever in the row.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one token in the cell row");

   // A token reaching the end of the row belongs to the running request.
   a_tail_running: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> run_ff)
      else $error("token left the row with no request running");

   // No result leaves the row while the spare slot is full.
   a_tail_no_hold: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> !hold_valid_ff)
      else $error("result left the row while the spare slot was full");

   // The spare slot is only used behind a waiting response.
   a_hold_behind: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("spare slot full with no response waiting");

   // An accepted request enters the first cell on the next edge.
   a_enter_row: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> chain[1].valid)
      else $error("accepted request did not enter the cell row");

endmodule

// File: rtl/rtt_cell.sv
module rtt_cell
   import rtt_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  wr_type             wr,
   input  logic [COUNT_W-1:0] entry_count,
   input  logic [VIEW_W-1:0]  view_mask,
   input  tok_type            up_tok,
   output tok_type            dn_tok
);

   // Entry contents, kept in a form that needs no add on the lookup path
   // other than the final offset and, for the physical lookups, its negation.
   logic [ADDR_W-1:0] vbase_ff;
   logic [ADDR_W-1:0] pbase_ff;
   logic [ADDR_W:0]   vend_ff;
   logic [ADDR_W:0]   pend_ff;
   logic [ADDR_W-1:0] v2p_ff;
   logic [VIEW_W-1:0] view_ff;
   logic              unc_ff;

   tok_type tok_ff;
   tok_type tok_in;

   logic              wr_hit;
   logic              sel_v;
   logic [ADDR_W-1:0] base;
   logic [ADDR_W:0]   lim;
   logic [ADDR_W-1:0] delta;
   logic              kind_ok;
   logic              active;
   logic              lo_ok;
   logic              hi_ok;
   logic              hit;

   assign wr_hit = wr.en && (SLOT_CMP_W'(wr.idx) == SLOT_CMP_W'(INDEX));

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         vbase_ff <= wr.vbase;
         pbase_ff <= wr.pbase;
         vend_ff  <= {1'b0, wr.vbase} + {1'b0, wr.len};
         pend_ff  <= {1'b0, wr.pbase} + {1'b0, wr.len};
         v2p_ff   <= wr.pbase - wr.vbase;
         view_ff  <= wr.attr[VIEW_LSB +: VIEW_W];
         unc_ff   <= wr.attr[UNCACHED_B];
      end
   end

   always_comb begin
      sel_v = (up_tok.func == FUNC_V2P) || (up_tok.func == FUNC_RANGE_CHECK);
      base  = sel_v ? vbase_ff : pbase_ff;
      lim   = sel_v ? vend_ff : pend_ff;
      delta = sel_v ? v2p_ff : (ADDR_W'(0) - v2p_ff);

      case (up_tok.func)
         FUNC_V2P:          kind_ok = 1'b1;
         FUNC_P2V_CACHED:   kind_ok = !unc_ff;
         FUNC_P2V_UNCACHED: kind_ok = unc_ff;
         FUNC_RANGE_CHECK:  kind_ok = 1'b1;
         default:           kind_ok = 1'b0;
      endcase

      active = (SLOT_CMP_W'(INDEX) < SLOT_CMP_W'(entry_count)) &&
               ((view_ff & view_mask) != '0);
      lo_ok  = up_tok.qa >= base;
      hi_ok  = (up_tok.func == FUNC_RANGE_CHECK) ? (up_tok.qend <= lim)
                                                 : ({1'b0, up_tok.qa} < lim);
      hit    = active && kind_ok && lo_ok && hi_ok;

      tok_in = up_tok;
      if (up_tok.valid && !up_tok.found && hit) begin
         tok_in.found = 1'b1;
         tok_in.addr  = (up_tok.func == FUNC_RANGE_CHECK) ? '0 : (up_tok.qa + delta);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

// File: sim/testbench.sv
// Self-checking bench for the range translation table. Each request transfer
// is handed to an in-bench translator that keeps its own copy of the table and
// of the two control registers. Each response transfer is compared with the
// oldest outstanding prediction. The run starts with a short scripted walk over
// the corner cases. It then runs random phases: load the slots that the next
// entry count will expose, reprogram the count and the view mask while the
// block is idle, and send a mix of table writes, lookups and unused codes. Most
// lookup addresses are aimed at the edges and the interior of loaded ranges.
module testbench;
   import rtt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS  = 64;
   localparam int RANDOM_ITEMS = 600;
   localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
   // Function codes that the block must ignore.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] vbase;
      logic [ADDR_W-1:0] pbase;
      logic [ADDR_W-1:0] len;
      logic [ADDR_W-1:0] attr;
      logic [ADDR_W-1:0] qa;
      logic [ADDR_W-1:0] qlen;
   } request_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] addr;
   } lookup_result_type;

   // One row of the scripted opening: either a register write or a request.
   // A request row either carries its answer or leaves it to the translator.
   typedef struct {
      bit                    is_csr;
      csr_reg_type           csr_sel;
      logic [CSR_DATA_W-1:0] csr_value;
      request_type           req;
      bit                    typed;
      logic                  want_found;
      logic [ADDR_W-1:0]     want_addr;
   } script_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [ADDR_W-1:0]     rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Shadow copy of the table and of the control registers.
   logic [ADDR_W-1:0] virt_tab [TABLE_SLOTS];
   logic [ADDR_W-1:0] phys_tab [TABLE_SLOTS];
   logic [ADDR_W-1:0] len_tab  [TABLE_SLOTS];
   logic [ADDR_W-1:0] attr_tab [TABLE_SLOTS];
   bit                loaded   [TABLE_SLOTS];
   logic [COUNT_W-1:0] active_count  = '0;
   logic [VIEW_W-1:0]  view_mask_reg = '0;

   lookup_result_type pending [$];
   int                mismatches = 0;
   // Percentage of cycles in which each side holds back.
   int                idle_pct   = 19;

   range_translation_table #(.ENTRIES(TABLE_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // A slot takes part when its view bits meet the view mask. The bound on
   // the entry count is applied by the callers.
   function automatic bit slot_on(int unsigned i);
      return (attr_tab[i][VIEW_LSB +: VIEW_W] & view_mask_reg) != '0;
   endfunction

   // Ends are formed one bit wider, so a range that reaches the top of the
   // address space does not wrap back to zero.
   function automatic bit hits(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] base,
                               logic [ADDR_W-1:0] len);
      return a >= base && {1'b0, a} < {1'b0, base} + {1'b0, len};
   endfunction

   // Predicts the response to one accepted request, and updates the shadow
   // table on a write.
   function automatic lookup_result_type translate(request_type r);
      lookup_result_type res;
      int unsigned       lim;
      logic              want_unc;
      logic [ADDR_W:0]   q_end;
      logic [ADDR_W:0]   e_end;
      res = '{found: 1'b0, addr: '0};
      lim = (active_count > TABLE_SLOTS) ? TABLE_SLOTS : active_count;
      want_unc = (r.func == FUNC_P2V_UNCACHED);
      q_end = {1'b0, r.qa} + {1'b0, r.qlen};
      if (r.func == FUNC_WRITE) begin
         virt_tab[r.idx] = r.vbase;
         phys_tab[r.idx] = r.pbase;
         len_tab[r.idx]  = r.len;
         attr_tab[r.idx] = r.attr;
         loaded[r.idx]   = 1'b1;
         res.found = 1'b1;
      end else if (r.func == FUNC_V2P) begin
         for (int i = 0; i < lim && !res.found; i++) begin
            if (slot_on(i) && hits(r.qa, virt_tab[i], len_tab[i])) begin
               res.found = 1'b1;
               res.addr  = phys_tab[i] + (r.qa - virt_tab[i]);
            end
         end
      end else if (r.func == FUNC_P2V_CACHED || r.func == FUNC_P2V_UNCACHED) begin
         for (int i = 0; i < lim && !res.found; i++) begin
            if (slot_on(i) && attr_tab[i][UNCACHED_B] == want_unc &&
                hits(r.qa, phys_tab[i], len_tab[i])) begin
               res.found = 1'b1;
               res.addr  = virt_tab[i] + (r.qa - phys_tab[i]);
            end
         end
      end else if (r.func == FUNC_RANGE_CHECK) begin
         for (int i = 0; i < lim && !res.found; i++) begin
            e_end = {1'b0, virt_tab[i]} + {1'b0, len_tab[i]};
            if (slot_on(i) && r.qa >= virt_tab[i] && q_end <= e_end) begin
               res.found = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Every field random, so the block is also shown bits it must ignore.
   function automatic request_type noise_request(logic [FUNC_W-1:0] f);
      request_type r;
      r.func  = f;
      r.idx   = IDX_W'($urandom);
      r.vbase = $urandom;
      r.pbase = $urandom;
      r.len   = $urandom;
      r.attr  = $urandom;
      r.qa    = $urandom;
      r.qlen  = $urandom;
      return r;
   endfunction

   function automatic request_type make_write(logic [IDX_W-1:0] slot);
      request_type r;
      int unsigned k;
      r = noise_request(FUNC_WRITE);
      r.idx = slot;
      case ($urandom_range(19))
         0:          r.len = '0;
         1:          r.len = 32'hFFFF_FFFF;
         2, 3:       r.len = $urandom;
         4, 5, 6, 7: r.len = $urandom & 32'h00FF_FFFF;
         default:    r.len = $urandom_range(4096, 1);
      endcase
      if ($urandom_range(9) == 0) r.vbase = 32'hFFFF_FFFF - $urandom_range(4095);
      if ($urandom_range(9) == 0) r.pbase = 32'hFFFF_FFFF - $urandom_range(4095);
      // Overlap with another loaded slot now and then, so that the lowest
      // index has to win.
      k = $urandom_range(TABLE_SLOTS - 1);
      if (loaded[k] && $urandom_range(3) == 0) begin
         r.vbase = virt_tab[k] + $urandom_range(64);
         r.pbase = phys_tab[k] + $urandom_range(64);
      end
      if ($urandom_range(1)) r.attr[VIEW_LSB +: VIEW_W] = VIEW_W'(1) << $urandom_range(VIEW_W - 1);
      return r;
   endfunction

   // Lookups mostly land on the edges or the inside of a slot in use. The
   // rest are random addresses.
   function automatic request_type make_lookup(logic [FUNC_W-1:0] f);
      request_type       r;
      int unsigned       lim;
      int unsigned       j;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] len;
      logic [ADDR_W:0]   room;
      r = noise_request(f);
      lim = (active_count > TABLE_SLOTS) ? TABLE_SLOTS : active_count;
      if (lim == 0 || $urandom_range(99) < 25) return r;
      j = $urandom_range(lim - 1);
      base = (f == FUNC_P2V_CACHED || f == FUNC_P2V_UNCACHED) ? phys_tab[j] : virt_tab[j];
      len  = len_tab[j];
      case ($urandom_range(5))
         0:       r.qa = base;
         1:       r.qa = base + len - 1;
         2:       r.qa = base + len;
         3:       r.qa = base - 1;
         default: r.qa = (len == '0) ? base : base + ($urandom % len);
      endcase
      room = {1'b0, base} + {1'b0, len} - {1'b0, r.qa};
      case ($urandom_range(3))
         0:       r.qlen = '0;
         1:       r.qlen = room[ADDR_W-1:0];
         2:       r.qlen = room[ADDR_W-1:0] + 1;
         default: r.qlen = $urandom_range(255);
      endcase
      return r;
   endfunction

   // Called at a falling edge. Returns at a falling edge with tvalid still
   // high, so that back-to-back transfers can follow without a gap.
   task automatic send(input request_type r, input bit typed = 1'b0,
                       input logic want_found = 1'b0,
                       input logic [ADDR_W-1:0] want_addr = '0);
      lookup_result_type res;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.func;
      req_tdata  <= {2'b00, r.qlen, r.qa, r.attr, r.len, r.pbase, r.vbase, r.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = translate(r);
      if (typed) res = '{found: want_found, addr: want_addr};
      pending.push_back(res);
      @(negedge clock);
   endtask

   // Stops the request stream and waits until every response is in. Each
   // request has exactly one response, so the block is then idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input csr_reg_type sel, input logic [CSR_DATA_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (sel == REG_ENTRY_COUNT) active_count = value[COUNT_W-1:0];
      else view_mask_reg = value[VIEW_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic script_row_type setup(int unsigned slot, logic [ADDR_W-1:0] vb,
                                            logic [ADDR_W-1:0] pb, logic [ADDR_W-1:0] ln,
                                            logic [ADDR_W-1:0] at);
      script_row_type s;
      s = '{is_csr: 1'b0, csr_sel: REG_ENTRY_COUNT, csr_value: '0,
            req: noise_request(FUNC_WRITE), typed: 1'b1, want_found: 1'b1, want_addr: '0};
      s.req.idx   = IDX_W'(slot);
      s.req.vbase = vb;
      s.req.pbase = pb;
      s.req.len   = ln;
      s.req.attr  = at;
      return s;
   endfunction

   function automatic script_row_type probe(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] qa,
                                            logic [ADDR_W-1:0] ql, bit typed = 1'b0,
                                            logic found = 1'b0, logic [ADDR_W-1:0] addr = '0);
      script_row_type s;
      s = '{is_csr: 1'b0, csr_sel: REG_ENTRY_COUNT, csr_value: '0,
            req: noise_request(f), typed: typed, want_found: found, want_addr: addr};
      s.req.qa   = qa;
      s.req.qlen = ql;
      return s;
   endfunction

   function automatic script_row_type cfg(csr_reg_type sel, logic [CSR_DATA_W-1:0] value);
      script_row_type s;
      s = '{is_csr: 1'b1, csr_sel: sel, csr_value: value,
            req: noise_request(FUNC_WRITE), typed: 1'b0, want_found: 1'b0, want_addr: '0};
      return s;
   endfunction

   // The response side stalls at random, just as the request side does.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // Every response transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending.size() == 0) begin
            flag_mismatch($sformatf("response transfer with nothing outstanding (found %0b addr %h)",
                                    rsp_tuser, rsp_tdata));
         end else begin
            want = pending.pop_front();
            if (rsp_tuser !== want.found)
               flag_mismatch($sformatf("found is %0b, predicted %0b", rsp_tuser, want.found));
            if (rsp_tdata !== want.addr)
               flag_mismatch($sformatf("out_addr is %h, predicted %h", rsp_tdata, want.addr));
         end
      end
   end

   initial begin
      script_row_type    script [$];
      int                random_done;
      int                phase;
      int unsigned       new_count;
      logic [VIEW_W-1:0] new_mask;
      logic [FUNC_W-1:0] f;

      // With the entry count at zero after reset, every lookup misses. Slot 1
      // is a zero-length range, and slot 2 ends exactly at the top of memory.
      script.push_back(probe(FUNC_V2P, 32'h0000_0000, 32'h0, 1'b1, 1'b0, '0));
      script.push_back(probe(FUNC_RANGE_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0));
      script.push_back(probe(FUNC_P2V_UNCACHED, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, '0));
      script.push_back(probe(FUNC_UNUSED_LAST, 32'h0000_1000, 32'h0, 1'b1, 1'b0, '0));
      script.push_back(setup(0, 32'h0000_1000, 32'h8000_0000, 32'h0000_1000, 32'h0001_0000));
      script.push_back(setup(1, 32'h0000_2000, 32'h0000_4000, 32'h0, 32'hBFFF_0000));
      script.push_back(setup(2, 32'hFFFF_FF00, 32'h0000_0100, 32'h0000_0100, 32'h4002_0000));
      script.push_back(setup(TABLE_SLOTS - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF));
      script.push_back(cfg(REG_ENTRY_COUNT, 16'd3));
      script.push_back(cfg(REG_VIEW_MASK, 16'hFFFF));
      script.push_back(probe(FUNC_V2P, 32'h0000_1000, 32'h0, 1'b1, 1'b1, 32'h8000_0000));
      script.push_back(probe(FUNC_V2P, 32'h0000_1FFF, 32'h0, 1'b1, 1'b1, 32'h8000_0FFF));
      script.push_back(probe(FUNC_V2P, 32'h0000_2000, 32'h0, 1'b1, 1'b0, '0));
      script.push_back(probe(FUNC_RANGE_CHECK, 32'h0000_2000, 32'h0));
      script.push_back(probe(FUNC_V2P, 32'hFFFF_FFFF, 32'h0));
      script.push_back(probe(FUNC_RANGE_CHECK, 32'hFFFF_FF00, 32'h0000_0100));
      script.push_back(probe(FUNC_RANGE_CHECK, 32'hFFFF_FF00, 32'h0000_0101));
      script.push_back(probe(FUNC_P2V_CACHED, 32'h8000_0800, 32'h0));
      script.push_back(probe(FUNC_P2V_UNCACHED, 32'h0000_0180, 32'h0));
      script.push_back(probe(FUNC_P2V_CACHED, 32'h0000_0180, 32'h0));
      script.push_back(cfg(REG_VIEW_MASK, 16'h0001));
      script.push_back(probe(FUNC_V2P, 32'hFFFF_FFFF, 32'h0));
      script.push_back(probe(FUNC_V2P, 32'h0000_1800, 32'h0));
      script.push_back(cfg(REG_VIEW_MASK, 16'h0000));
      script.push_back(probe(FUNC_V2P, 32'h0000_1000, 32'h0, 1'b1, 1'b0, '0));
      script.push_back(probe(FUNC_UNUSED_FIRST, 32'h0000_1000, 32'h0, 1'b1, 1'b0, '0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_csr)
            write_csr(script[k].csr_sel, script[k].csr_value);
         else
            send(script[k].req, script[k].typed, script[k].want_found, script[k].want_addr);
      end

      // Random phases. The first one opens the whole table, and the second
      // one sets the widest entry count. The third one runs with no idling
      // on either side.
      random_done = 0;
      phase = 0;
      while (random_done < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0:       new_count = 0;
            1, 2:    new_count = TABLE_SLOTS;
            3:       new_count = $urandom_range(COUNT_MAX, TABLE_SLOTS + 1);
            default: new_count = $urandom_range(TABLE_SLOTS - 1, 1);
         endcase
         case ($urandom_range(9))
            0:          new_mask = '0;
            1, 2:       new_mask = VIEW_W'(1) << $urandom_range(VIEW_W - 1);
            3, 4, 5:    new_mask = VIEW_W'($urandom);
            default:    new_mask = '1;
         endcase
         if (phase == 0) begin
            new_count = TABLE_SLOTS;
            new_mask  = '1;
         end
         if (phase == 1) new_count = COUNT_MAX;
         idle_pct = (phase == 2) ? 0 : 19;

         // Any slot that the new count exposes must hold an entry first.
         for (int i = 0; i < TABLE_SLOTS && i < new_count; i++) begin
            if (!loaded[i]) begin
               send(make_write(IDX_W'(i)));
               random_done++;
            end
         end
         write_csr(REG_ENTRY_COUNT, CSR_DATA_W'(new_count));
         write_csr(REG_VIEW_MASK, new_mask);

         repeat ($urandom_range(80, 40)) begin
            case ($urandom_range(3))
               0:       f = FUNC_V2P;
               1:       f = FUNC_P2V_CACHED;
               2:       f = FUNC_P2V_UNCACHED;
               default: f = FUNC_RANGE_CHECK;
            endcase
            case ($urandom_range(19))
               0, 1, 2, 3: begin
                  send(make_write(IDX_W'($urandom_range(TABLE_SLOTS - 1))));
                  random_done++;
               end
               4: begin
                  send(noise_request(FUNC_W'($urandom_range(FUNC_UNUSED_LAST,
                                                             FUNC_UNUSED_FIRST))));
                  random_done++;
               end
               default: begin
                  send(make_lookup(f));
                  random_done++;
               end
            endcase
         end
         phase++;
      end

      drain();
      repeat (TABLE_SLOTS + 8) @(negedge clock);
      if (pending.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending.size()));
      if (mismatches == 0) begin
         $display("PASS range_translation_table");
      end else begin
         $display("FAIL range_translation_table");
      end
      $finish;
   end

   // Watchdog, set far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAIL range_translation_table");
      $finish;
   end

endmodule
